>>> sv/ihex_pkg.sv
package ihex_pkg;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;
  localparam logic [7:0] TYPE_XSEG = 8'h02;
  localparam logic [7:0] TYPE_SSEG = 8'h03;
  localparam logic [7:0] TYPE_XLIN = 8'h04;
  localparam logic [7:0] TYPE_SLIN = 8'h05;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_EOF    = 2'd3;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_STRAY = 3'd1;
  localparam logic [2:0] ERR_DIGIT = 3'd2;
  localparam logic [2:0] ERR_SUM   = 3'd3;
  localparam logic [2:0] ERR_TYPE  = 3'd4;

  localparam logic [31:0] LINEAR_MASK = 32'hFFFF0000;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [7:0]  rec_type;
    logic [2:0]  error_code;
    logic [31:0] start_address;
  } ihex_result_t;

endpackage

>>> sv/ihex_if.sv
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source(output valid, output char_in, input ready);
  modport sink(input valid, input char_in, output ready);
endinterface

interface ihex_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] byte_address;
  logic [7:0]  data_byte;
  logic [7:0]  rec_type;
  logic [2:0]  error_code;
  logic [31:0] start_address;

  modport source(output valid, output result_kind, output byte_address, output data_byte,
                 output rec_type, output error_code, output start_address, input ready);
  modport sink(input valid, input result_kind, input byte_address, input data_byte,
               input rec_type, input error_code, input start_address, output ready);
endinterface

>>> sv/intel_hex_record_parser.sv
// Intel HEX parser taking one ASCII character per word and giving at most one result word
// per character: a data byte with its full address, or the verdict on a record at its
// checksum or at its first bad character. It accepts a character in every cycle while its
// result register is free or being read out; a character passes an input register and then
// a result register before its result word is offered.
// Data bytes go out before the checksum is checked, so a consumer must drop the bytes of a
// record that is then reported as rejected. After a rejection or an end-of-file record the
// block ignores all further characters until reset.
module intel_hex_record_parser (
  input  logic          clk,
  input  logic          rst,
  ihex_char_if.sink     chars,
  ihex_result_if.source results
);
  import ihex_pkg::*;

  logic         advance;
  logic         char_valid;
  logic [7:0]   char_q;
  logic         res_load;
  ihex_result_t res;

  ihex_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .advance    (advance),
    .char_valid (char_valid),
    .char_q     (char_q)
  );

  ihex_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (char_valid && advance),
    .char_in  (char_q),
    .res_load (res_load),
    .res      (res)
  );

  ihex_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res      (res),
    .advance  (advance),
    .results  (results)
  );

endmodule

>>> sv/ihex_in_reg.sv
module ihex_in_reg (
  input  logic        clk,
  input  logic        rst,
  ihex_char_if.sink   chars,
  input  logic        advance,
  output logic        char_valid,
  output logic [7:0]  char_q
);

  logic take;

  assign chars.ready = !char_valid || advance;
  assign take        = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (take) begin
      char_valid <= 1'b1;
    end else if (advance) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_q <= chars.char_in;
    end
  end

endmodule

>>> sv/ihex_core.sv
module ihex_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            char_in,
  output logic                  res_load,
  output ihex_pkg::ihex_result_t res
);
  import ihex_pkg::*;

  typedef enum logic [2:0] {
    PH_COLON, PH_LENGTH, PH_OFFSET, PH_TYPE, PH_DATA, PH_CHECK
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  high_nibble;
    logic        nibble_second;
    logic [7:0]  field_byte_count;
    logic [7:0]  record_length;
    logic [15:0] record_offset;
    logic [7:0]  record_kind;
    logic [7:0]  running_sum;
    logic [31:0] base_address;
    logic [31:0] payload_value;
    logic        halted;
  } state_t;

  state_t      st;
  state_t      st_next;
  logic        nib_ok;
  logic [3:0]  nib;
  logic [7:0]  byte_value;
  logic [7:0]  sum_next;
  logic [7:0]  count_inc;
  logic        rej;
  logic [7:0]  rej_type;
  logic [2:0]  rej_err;

  always_comb begin
    logic [7:0] diff;
    diff   = '0;
    nib_ok = 1'b1;
    if (char_in >= CH_ZERO && char_in <= CH_NINE) begin
      diff = char_in - CH_ZERO;
    end else if (char_in >= CH_UPPER_A && char_in <= CH_UPPER_F) begin
      diff = char_in - CH_UPPER_A + HEX_TEN;
    end else if (char_in >= CH_LOWER_A && char_in <= CH_LOWER_F) begin
      diff = char_in - CH_LOWER_A + HEX_TEN;
    end else begin
      nib_ok = 1'b0;
    end
    nib = diff[3:0];
  end

  assign byte_value = {st.high_nibble, nib};
  assign sum_next   = st.running_sum + byte_value;
  assign count_inc  = st.field_byte_count + 8'd1;

  always_comb begin
    st_next  = st;
    res_load = 1'b0;
    res      = '0;
    rej      = 1'b0;
    rej_type = st.record_kind;
    rej_err  = ERR_NONE;
    if (step && !st.halted) begin
      if (st.phase == PH_COLON) begin
        if (char_in == CH_CR || char_in == CH_LF) begin
          st_next = st;
        end else if (char_in != CH_COLON) begin
          rej      = 1'b1;
          rej_type = '0;
          rej_err  = ERR_STRAY;
        end else begin
          st_next.phase            = PH_LENGTH;
          st_next.high_nibble      = '0;
          st_next.nibble_second    = 1'b0;
          st_next.field_byte_count = '0;
          st_next.record_length    = '0;
          st_next.record_offset    = '0;
          st_next.record_kind      = '0;
          st_next.running_sum      = '0;
          st_next.payload_value    = '0;
        end
      end else if (!nib_ok) begin
        rej     = 1'b1;
        rej_err = ERR_DIGIT;
      end else if (!st.nibble_second) begin
        st_next.high_nibble   = nib;
        st_next.nibble_second = 1'b1;
      end else begin
        st_next.nibble_second = 1'b0;
        st_next.running_sum   = sum_next;
        unique case (st.phase)
          PH_LENGTH: begin
            st_next.record_length    = byte_value;
            st_next.field_byte_count = '0;
            st_next.phase            = PH_OFFSET;
          end
          PH_OFFSET: begin
            st_next.record_offset    = {st.record_offset[7:0], byte_value};
            st_next.field_byte_count = count_inc;
            if (count_inc >= 8'd2) begin
              st_next.phase = PH_TYPE;
            end
          end
          PH_TYPE: begin
            st_next.record_kind      = byte_value;
            st_next.field_byte_count = '0;
            st_next.payload_value    = '0;
            st_next.phase            = (st.record_length != '0) ? PH_DATA : PH_CHECK;
          end
          PH_DATA: begin
            st_next.payload_value    = {st.payload_value[23:0], byte_value};
            st_next.field_byte_count = count_inc;
            if (count_inc >= st.record_length) begin
              st_next.phase = PH_CHECK;
            end
            if (st.record_kind == TYPE_DATA) begin
              res_load         = 1'b1;
              res.result_kind  = KIND_BYTE;
              res.byte_address = st.base_address + {16'b0, st.record_offset}
                                 + {24'b0, st.field_byte_count};
              res.data_byte    = byte_value;
              res.rec_type     = st.record_kind;
            end
          end
          PH_CHECK: begin
            st_next.phase = PH_COLON;
            if (sum_next != '0) begin
              rej     = 1'b1;
              rej_err = ERR_SUM;
            end else begin
              res.rec_type    = st.record_kind;
              res.result_kind = KIND_ACCEPT;
              res_load        = 1'b1;
              unique case (st.record_kind)
                TYPE_DATA: begin
                  res.result_kind = KIND_ACCEPT;
                end
                TYPE_EOF: begin
                  st_next.halted  = 1'b1;
                  res.result_kind = KIND_EOF;
                end
                TYPE_XSEG: begin
                  st_next.base_address = {12'b0, st.payload_value[15:0], 4'b0};
                end
                TYPE_XLIN: begin
                  st_next.base_address = {st.payload_value[15:0], 16'b0} & LINEAR_MASK;
                end
                TYPE_SSEG, TYPE_SLIN: begin
                  res.start_address = st.payload_value;
                end
                default: begin
                  res_load = 1'b0;
                  rej      = 1'b1;
                  rej_err  = ERR_TYPE;
                end
              endcase
            end
          end
          default: begin
            st_next = st;
          end
        endcase
      end
      if (rej) begin
        st_next.halted  = 1'b1;
        st_next.phase   = PH_COLON;
        res_load        = 1'b1;
        res             = '0;
        res.result_kind = KIND_REJECT;
        res.rec_type    = rej_type;
        res.error_code  = rej_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

>>> sv/ihex_out_reg.sv
module ihex_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_load,
  input  ihex_pkg::ihex_result_t res,
  output logic                   advance,
  ihex_result_if.source          results
);
  import ihex_pkg::*;

  ihex_result_t res_q;
  logic         res_valid;

  assign advance = !res_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_load) begin
      res_q <= res;
    end
  end

  assign results.valid         = res_valid;
  assign results.result_kind   = res_q.result_kind;
  assign results.byte_address  = res_q.byte_address;
  assign results.data_byte     = res_q.data_byte;
  assign results.rec_type      = res_q.rec_type;
  assign results.error_code    = res_q.error_code;
  assign results.start_address = res_q.start_address;

endmodule

>>> sv/ihex_checker.sv
module ihex_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [2:0]  error_code,
  input logic [31:0] start_address
);
  import ihex_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(error_code)
                                && $stable(start_address))
    else $error("Stalled result word changed.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (result_kind == KIND_REJECT || result_kind == KIND_EOF)
    |=> !out_valid)
    else $error("Result word after the parser halted.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result_kind == KIND_REJECT) == (error_code != ERR_NONE)))
    else $error("Error code does not match the result kind.");

  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while the result register is empty.");

endmodule

bind intel_hex_record_parser ihex_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (chars.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .result_kind   (results.result_kind),
  .error_code    (results.error_code),
  .start_address (results.start_address)
);

>>> dv/intel_hex_record_parser_checker.sv
`timescale 1ns / 1ps

module intel_hex_record_parser_checker (
  input  logic   clk,
  input  logic   rst,
  ihex_char_if   chars,
  ihex_result_if results,
  output int     errors,
  output int     pending,
  output int     data_bytes,
  output int     records
);
  import ihex_pkg::*;

  typedef enum logic [2:0] {
    FIELD_COLON, FIELD_LENGTH, FIELD_OFFSET, FIELD_TYPE, FIELD_DATA, FIELD_SUM
  } field_e;

  field_e       field;
  logic [3:0]   upper_nibble;
  logic         second_digit;
  logic [7:0]   bytes_in_field;
  logic [7:0]   data_length;
  logic [15:0]  offset_field;
  logic [7:0]   type_byte;
  logic [7:0]   byte_sum;
  logic [31:0]  base;
  logic [31:0]  payload;
  logic         stopped;
  ihex_result_t due_results[$];

  function automatic int digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A + HEX_TEN);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A + HEX_TEN);
    return -1;
  endfunction

  task automatic post(input logic [1:0] kind, input logic [31:0] addr, input logic [7:0] value,
                      input logic [7:0] rtype, input logic [2:0] err, input logic [31:0] start);
    ihex_result_t r;
    r.result_kind   = kind;
    r.byte_address  = addr;
    r.data_byte     = value;
    r.rec_type      = rtype;
    r.error_code    = err;
    r.start_address = start;
    due_results.push_back(r);
  endtask

  task automatic halt_with(input logic [7:0] rtype, input logic [2:0] err);
    stopped = 1'b1;
    field = FIELD_COLON;
    post(KIND_REJECT, '0, '0, rtype, err, '0);
  endtask

  task automatic parse_char(input logic [7:0] c);
    int         digit;
    logic [7:0] b;
    logic [7:0] index;
    if (stopped) return;
    if (field == FIELD_COLON) begin
      if (c == CH_CR || c == CH_LF) return;
      if (c != CH_COLON) begin
        halt_with(8'h00, ERR_STRAY);
        return;
      end
      field = FIELD_LENGTH;
      upper_nibble = '0;
      second_digit = 1'b0;
      bytes_in_field = '0;
      data_length = '0;
      offset_field = '0;
      type_byte = '0;
      byte_sum = '0;
      payload = '0;
      return;
    end
    digit = digit_value(c);
    if (digit < 0) begin
      halt_with(type_byte, ERR_DIGIT);
      return;
    end
    if (!second_digit) begin
      upper_nibble = digit[3:0];
      second_digit = 1'b1;
      return;
    end
    second_digit = 1'b0;
    b = {upper_nibble, digit[3:0]};
    byte_sum = byte_sum + b;
    case (field)
      FIELD_LENGTH: begin
        data_length = b;
        bytes_in_field = '0;
        field = FIELD_OFFSET;
      end
      FIELD_OFFSET: begin
        offset_field = {offset_field[7:0], b};
        bytes_in_field++;
        if (bytes_in_field >= 8'd2) field = FIELD_TYPE;
      end
      FIELD_TYPE: begin
        type_byte = b;
        bytes_in_field = '0;
        payload = '0;
        field = (data_length != 8'd0) ? FIELD_DATA : FIELD_SUM;
      end
      FIELD_DATA: begin
        index = bytes_in_field;
        payload = {payload[23:0], b};
        bytes_in_field++;
        if (bytes_in_field >= data_length) field = FIELD_SUM;
        if (type_byte == TYPE_DATA) begin
          post(KIND_BYTE, base + 32'(offset_field) + 32'(index), b, type_byte, ERR_NONE, '0);
        end
      end
      default: begin
        field = FIELD_COLON;
        if (byte_sum != 8'd0) begin
          halt_with(type_byte, ERR_SUM);
        end else begin
          case (type_byte)
            TYPE_DATA: post(KIND_ACCEPT, '0, '0, type_byte, ERR_NONE, '0);
            TYPE_EOF: begin
              stopped = 1'b1;
              post(KIND_EOF, '0, '0, type_byte, ERR_NONE, '0);
            end
            TYPE_XSEG: begin
              base = {12'h000, payload[15:0], 4'h0};
              post(KIND_ACCEPT, '0, '0, type_byte, ERR_NONE, '0);
            end
            TYPE_XLIN: begin
              base = {payload[15:0], 16'h0000} & LINEAR_MASK;
              post(KIND_ACCEPT, '0, '0, type_byte, ERR_NONE, '0);
            end
            TYPE_SSEG, TYPE_SLIN: post(KIND_ACCEPT, '0, '0, type_byte, ERR_NONE, payload);
            default: halt_with(type_byte, ERR_TYPE);
          endcase
        end
      end
    endcase
  endtask

  function automatic void compare(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    ihex_result_t want;
    if (rst) begin
      field = FIELD_COLON;
      upper_nibble = '0;
      second_digit = 1'b0;
      bytes_in_field = '0;
      data_length = '0;
      offset_field = '0;
      type_byte = '0;
      byte_sum = '0;
      base = '0;
      payload = '0;
      stopped = 1'b0;
      due_results.delete();
    end else begin
      if (chars.valid === 1'b1 && chars.ready === 1'b1) parse_char(chars.char_in);
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word expected none, got kind %0d address %h byte %h",
                   $time, results.result_kind, results.byte_address, results.data_byte);
          errors++;
        end else begin
          want = due_results.pop_front();
          compare("result_kind", 32'(want.result_kind), 32'(results.result_kind));
          compare("byte_address", want.byte_address, results.byte_address);
          compare("data_byte", 32'(want.data_byte), 32'(results.data_byte));
          compare("rec_type", 32'(want.rec_type), 32'(results.rec_type));
          compare("error_code", 32'(want.error_code), 32'(results.error_code));
          compare("start_address", want.start_address, results.start_address);
          if (want.result_kind == KIND_BYTE) data_bytes++;
          else if (want.result_kind == KIND_ACCEPT) records++;
        end
      end
    end
    pending = due_results.size();
  end

endmodule

>>> dv/intel_hex_record_parser_test.sv
`timescale 1ns / 1ps

module intel_hex_record_parser_test;
  import ihex_pkg::*;

  localparam int RANDOM_CHARS = 1950;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NO_BAD_DIGIT = -1;

  typedef enum int {ENDS_EOF, ENDS_STRAY, ENDS_DIGIT, ENDS_SUM, ENDS_TYPE} ending_e;
  typedef enum int {UPPER_CASE, LOWER_CASE, MIXED_CASE} letters_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         sent_chars;
  int         cycle_count;
  int         mismatches;
  int         outstanding;
  int         bytes_seen;
  int         records_seen;
  int         idle_phase;
  bit         pressure_done;
  logic [7:0] record_data[$];
  ending_e    ending;

  ihex_char_if   chars();
  ihex_result_if results();

  intel_hex_record_parser i_dut (
    .clk(clk),
    .rst(rst),
    .chars(chars.sink),
    .results(results.source)
  );

  intel_hex_record_parser_checker i_checker (
    .clk(clk),
    .rst(rst),
    .chars(chars),
    .results(results),
    .errors(mismatches),
    .pending(outstanding),
    .data_bytes(bytes_seen),
    .records(records_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("intel_hex_record_parser_test: done, errors");
      $finish;
    end
  end

  function automatic int idle_percent(input bit receiver);
    case (idle_phase)
      0: return receiver ? 49 : 31;
      1: return receiver ? 31 : 49;
      default: return 0;
    endcase
  endfunction

  // The receiver holds off once for a long stretch so that the block backs up into its input.
  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !pressure_done && idle_phase == 2) begin
        results.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end
      results.ready <= rst ? 1'b0 : ($urandom_range(99) >= idle_percent(1'b1));
    end
  end

  task automatic send_char(input logic [7:0] c);
    idle_phase <= (sent_chars < 700) ? 0 : (sent_chars < 1400) ? 1 : 2;
    while ($urandom_range(99) < idle_percent(1'b0)) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid <= 1'b1;
    chars.char_in <= c;
    @(posedge clk);
    while (chars.ready !== 1'b1) @(posedge clk);
    sent_chars++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - HEX_TEN;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_COLON;
      default: begin
        do c = 8'($urandom_range(255));
        while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_F));
        return c;
      end
    endcase
  endfunction

  task automatic fill_data(input int len);
    record_data.delete();
    repeat (len) begin
      case ($urandom_range(7))
        0: record_data.push_back(8'h00);
        1: record_data.push_back(8'hFF);
        default: record_data.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic send_breaks();
    int n;
    n = $urandom_range(3);
    repeat (n) send_char($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  task automatic send_record(input logic [7:0] rtype, input logic [15:0] offset,
                             input letters_e letters, input logic [7:0] sum_flip,
                             input int bad_digit);
    logic [7:0] fields[$];
    logic [7:0] sum;
    logic [3:0] n;
    bit         lower;
    int         pos;
    fields.push_back(8'(record_data.size()));
    fields.push_back(offset[15:8]);
    fields.push_back(offset[7:0]);
    fields.push_back(rtype);
    foreach (record_data[i]) fields.push_back(record_data[i]);
    sum = 8'h00;
    foreach (fields[i]) sum += fields[i];
    fields.push_back((8'h00 - sum) ^ sum_flip);
    send_char(CH_COLON);
    pos = 0;
    foreach (fields[i]) begin
      for (int d = 0; d < 2; d++) begin
        if (pos == bad_digit) begin
          send_char(bad_char());
          return;
        end
        n = (d == 0) ? fields[i][7:4] : fields[i][3:0];
        lower = (letters == MIXED_CASE) ? 1'($urandom_range(1)) : (letters == LOWER_CASE);
        send_char(hex_char(n, lower));
        pos++;
      end
    end
  endtask

  task automatic send_random_record();
    logic [7:0]  rtype;
    logic [15:0] offset;
    int          pick;
    int          len;
    pick = $urandom_range(99);
    if (pick < 60) rtype = TYPE_DATA;
    else if (pick < 70) rtype = TYPE_XSEG;
    else if (pick < 80) rtype = TYPE_XLIN;
    else if (pick < 90) rtype = TYPE_SSEG;
    else rtype = TYPE_SLIN;
    case (rtype)
      TYPE_DATA: begin
        if ($urandom_range(29) == 0) len = $urandom_range(1) ? 255 : $urandom_range(17, 255);
        else len = $urandom_range(16);
      end
      TYPE_XSEG, TYPE_XLIN: len = ($urandom_range(3) == 0) ? $urandom_range(5) : 2;
      default: len = ($urandom_range(3) == 0) ? $urandom_range(7) : 4;
    endcase
    fill_data(len);
    case ($urandom_range(7))
      0: offset = 16'h0000;
      1: offset = 16'hFFFF;
      default: offset = 16'($urandom_range(16'hFFFF));
    endcase
    send_breaks();
    send_record(rtype, offset, MIXED_CASE, 8'h00, NO_BAD_DIGIT);
  endtask

  initial begin
    logic [7:0] c;
    chars.valid <= 1'b0;
    chars.char_in <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // A linear base of all ones puts the next data record at the top of the address space,
    // so its second byte wraps to address zero.
    record_data.delete();
    record_data.push_back(8'hFF);
    record_data.push_back(8'hFF);
    send_record(TYPE_XLIN, 16'h0000, LOWER_CASE, 8'h00, NO_BAD_DIGIT);
    send_char(CH_CR);
    send_char(CH_LF);
    record_data.delete();
    record_data.push_back(8'h00);
    record_data.push_back(8'hFF);
    send_record(TYPE_DATA, 16'hFFFF, UPPER_CASE, 8'h00, NO_BAD_DIGIT);

    while (sent_chars < RANDOM_CHARS) send_random_record();

    // Only one ending can stop the block, so the run picks which one.
    ending = ending_e'($urandom_range(4));
    send_breaks();
    case (ending)
      ENDS_EOF: begin
        fill_data($urandom_range(2));
        send_record(TYPE_EOF, 16'h0000, MIXED_CASE, 8'h00, NO_BAD_DIGIT);
      end
      ENDS_STRAY: begin
        do c = 8'($urandom_range(255));
        while (c == CH_CR || c == CH_LF || c == CH_COLON);
        send_char(c);
      end
      ENDS_DIGIT: begin
        fill_data($urandom_range(4));
        send_record(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), MIXED_CASE, 8'h00,
                    $urandom_range(2 * (record_data.size() + 5) - 1));
      end
      ENDS_SUM: begin
        fill_data($urandom_range(4));
        send_record(8'($urandom_range(7)), 16'($urandom_range(16'hFFFF)), MIXED_CASE,
                    8'($urandom_range(1, 255)), NO_BAD_DIGIT);
      end
      default: begin
        fill_data($urandom_range(4));
        send_record(8'($urandom_range(6, 255)), 16'($urandom_range(16'hFFFF)), MIXED_CASE,
                    8'h00, NO_BAD_DIGIT);
      end
    endcase

    // The block is stopped now and every further word must be dropped without a result.
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_COLON);
    repeat (40) send_char(8'($urandom_range(255)));
    chars.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("intel_hex_record_parser_test: %0d characters sent, %0d records and %0d data bytes",
             sent_chars, records_seen, bytes_seen);
    $display("intel_hex_record_parser_test: stopped by %s, output held off %0d cycles once",
             ending.name(), STALL_CYCLES);
    if (mismatches == 0) begin
      $display("intel_hex_record_parser_test: done, clean");
    end else begin
      $display("intel_hex_record_parser_test: done, errors");
    end
    $finish;
  end

endmodule
